// File: hw/rtl/lpsb_pkg.sv
package lpsb_pkg;

    // field widths
    localparam int ANGLE_W   = 16;
    localparam int DIST_W    = 16;
    localparam int INTEN_W   = 8;
    localparam int RBIN_W    = 9;
    localparam int OBIN_W    = 9;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // angular binning
    localparam int NUM_BINS  = 460;
    localparam int TURN_CDEG = 36000;
    localparam int HALF_TURN = TURN_CDEG / 2;
    localparam int BIN_W     = $clog2(NUM_BINS);

    // bin = floor((angle * NUM_BINS + HALF_TURN) / TURN_CDEG) by reciprocal multiply
    localparam longint X_MAX = longint'(65535) * NUM_BINS + HALF_TURN;
    localparam int     X_W   = $clog2(X_MAX + 1);
    localparam int     DIV_W = $clog2(TURN_CDEG);
    localparam int     SHIFT = X_W + DIV_W;
    localparam longint MAGIC = ((longint'(1) << SHIFT) + TURN_CDEG - 1) / TURN_CDEG;
    localparam int     M_W   = $clog2(MAGIC + 1);
    localparam int     P_W   = X_W + M_W;
    localparam longint Q_MAX = X_MAX / TURN_CDEG;
    localparam int     Q_W   = $clog2(Q_MAX + 1);

    // written-flag bitmap: rows of 32 bins, one row-valid flop per row
    localparam int LANE_W  = 5;
    localparam int ROW_W   = 1 << LANE_W;
    localparam int ROWS    = (NUM_BINS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int VA_W    = ROW_AW + 1;
    localparam int V_DEPTH = 1 << VA_W;
    localparam int V_HALF  = V_DEPTH / 2;

    // range / intensity store, both banks
    localparam int D_DEPTH = 2 * NUM_BINS;
    localparam int DA_W    = $clog2(D_DEPTH);
    localparam int DD_W    = DIST_W + INTEN_W;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RANGE = 2'd0,
        CFG_MAX_RANGE = 2'd1,
        CFG_WRAP_DROP = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [DIST_W-1:0]  min_range_mm;
        logic [DIST_W-1:0]  max_range_mm;
        logic [ANGLE_W-1:0] wrap_drop;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic [ANGLE_W-1:0] angle_cdeg;
        logic [DIST_W-1:0]  distance_mm;
        logic [INTEN_W-1:0] intensity;
        logic               packet_end;
        logic [RBIN_W-1:0]  read_bin;
    } t_item;

    typedef struct packed {
        logic               revolution_done;
        logic [OBIN_W-1:0]  bin_index;
        logic               point_kept;
        logic [DIST_W-1:0]  range_mm;
        logic [INTEN_W-1:0] bin_intensity;
        logic               bin_valid;
    } t_res;

    function automatic logic [ROW_AW-1:0] row_of(input logic [BIN_W-1:0] b);
        return ROW_AW'(32'(b) >> LANE_W);
    endfunction

    function automatic logic [LANE_W-1:0] lane_of(input logic [BIN_W-1:0] b);
        return LANE_W'(32'(b));
    endfunction

endpackage

// File: hw/rtl/lpsb_bin_map.sv
module lpsb_bin_map (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  lpsb_pkg::t_item        i_item,
    output logic                   o_valid,
    output lpsb_pkg::t_item        o_item,
    output logic [lpsb_pkg::Q_W-1:0] o_q,
    output logic [1:0]             o_fill
);
    import lpsb_pkg::*;

    logic           r_s1_valid;
    t_item          r_s1_item;
    logic [X_W-1:0] r_s1_x;
    logic           r_s2_valid;
    t_item          r_s2_item;
    logic [Q_W-1:0] r_s2_q;
    logic [P_W-1:0] n_prod;

    always_comb begin
        n_prod = P_W'(r_s1_x) * P_W'(MAGIC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= i_item;
        r_s1_x    <= X_W'(i_item.angle_cdeg) * X_W'(NUM_BINS) + X_W'(HALF_TURN);
        r_s2_item <= r_s1_item;
        r_s2_q    <= Q_W'(n_prod >> SHIFT);
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;
    assign o_q     = r_s2_q;
    assign o_fill  = {1'b0, r_s1_valid} + {1'b0, r_s2_valid};

endmodule

// File: hw/rtl/lpsb_scan_core.sv
module lpsb_scan_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lpsb_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    input  lpsb_pkg::t_item        i_item,
    input  logic [lpsb_pkg::Q_W-1:0] i_q,
    output logic                   o_push,
    output lpsb_pkg::t_res         o_res
);
    import lpsb_pkg::*;

    typedef struct packed {
        logic              mode;
        logic              done;
        logic [BIN_W-1:0]  bin;
        logic              kept;
        logic              wr;
        logic              in_range;
        logic [VA_W-1:0]   vaddr;
        logic [LANE_W-1:0] lane;
    } t_s3;

    logic               r_bank;
    logic [ANGLE_W-1:0] r_prev_angle;

    logic [DD_W-1:0]  dmem [D_DEPTH];
    logic [ROW_W-1:0] vmem [V_DEPTH];
    logic [DD_W-1:0]  r_drd;
    logic [ROW_W-1:0] r_vrd;
    logic [V_DEPTH-1:0] r_rv;
    logic [V_DEPTH-1:0] n_rv;

    logic              r_s3_valid;
    t_s3               r_s3;
    t_s3               n_s3;

    logic              r_vw_en;
    logic [VA_W-1:0]   r_vw_addr;
    logic [ROW_W-1:0]  r_vw_data;

    logic [BIN_W-1:0]   d_bin;
    logic [BIN_W-1:0]   d_idx;
    logic               d_sel;
    logic               d_point;
    logic               d_kept;
    logic               d_done;
    logic               d_wr;
    logic [ANGLE_W:0]   d_sum;
    logic [DA_W-1:0]    d_daddr;
    logic [VA_W-1:0]    d_vaddr;

    logic               e_wr;
    logic               e_fwd;
    logic [ROW_W-1:0]   e_base;
    logic [ROW_W-1:0]   e_row;
    logic               e_hit;

    // issue stage: bin, filter, revolution check, memory access
    always_comb begin
        d_bin   = (i_q >= Q_W'(NUM_BINS)) ? '0 : BIN_W'(i_q);
        d_point = i_valid && !i_item.mode;
        d_kept  = (i_item.distance_mm > i_cfg.min_range_mm)
               && (i_item.distance_mm < i_cfg.max_range_mm);
        d_sum   = {1'b0, i_item.angle_cdeg} + {1'b0, i_cfg.wrap_drop};
        d_done  = d_point && i_item.packet_end && (d_sum < {1'b0, r_prev_angle});
        d_wr    = d_point && d_kept;
        d_sel   = i_item.mode ? !r_bank : r_bank;
        d_idx   = i_item.mode ? BIN_W'(i_item.read_bin) : d_bin;
        d_daddr = (d_sel ? DA_W'(NUM_BINS) : DA_W'(0)) + DA_W'(d_idx);
        d_vaddr = {d_sel, row_of(d_idx)};

        n_s3.mode     = i_item.mode;
        n_s3.done     = d_done;
        n_s3.bin      = d_bin;
        n_s3.kept     = d_kept;
        n_s3.wr       = d_wr;
        n_s3.in_range = 32'(i_item.read_bin) < 32'(NUM_BINS);
        n_s3.vaddr    = d_vaddr;
        n_s3.lane     = lane_of(d_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank       <= 1'b0;
            r_prev_angle <= '0;
            r_s3_valid   <= 1'b0;
            r_vw_en      <= 1'b0;
        end else begin
            r_s3_valid <= i_valid;
            r_vw_en    <= e_wr;
            if (d_point && i_item.packet_end) begin
                r_prev_angle <= i_item.angle_cdeg;
            end
            if (d_done) begin
                r_bank <= !r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3      <= n_s3;
        r_vw_addr <= r_s3.vaddr;
        r_vw_data <= e_row;
    end

    always_ff @(posedge i_clk) begin
        if (d_wr) begin
            dmem[d_daddr] <= {i_item.distance_mm, i_item.intensity};
        end
        r_drd <= dmem[d_daddr];
    end

    // modify stage: merge the bin flag into its row, forward the last write
    always_comb begin
        e_wr   = r_s3_valid && r_s3.wr;
        e_fwd  = r_vw_en && (r_vw_addr == r_s3.vaddr);
        e_base = r_rv[r_s3.vaddr] ? (e_fwd ? r_vw_data : r_vrd) : '0;
        e_row  = e_base | (ROW_W'(1) << r_s3.lane);
        e_hit  = e_base[r_s3.lane];
    end

    always_ff @(posedge i_clk) begin
        if (e_wr) begin
            vmem[r_s3.vaddr] <= e_row;
        end
        r_vrd <= vmem[d_vaddr];
    end

    // clearing the new active bank wins over a late set into it
    always_comb begin
        n_rv = r_rv;
        for (int k = 0; k < V_DEPTH; k++) begin
            if (d_done && ((k >= V_HALF) == !r_bank)) begin
                n_rv[k] = 1'b0;
            end else if (e_wr && (r_s3.vaddr == VA_W'(k))) begin
                n_rv[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else begin
            r_rv <= n_rv;
        end
    end

    always_comb begin
        o_res = '0;
        if (r_s3.mode) begin
            o_res.bin_valid = r_s3.in_range && e_hit;
            if (o_res.bin_valid) begin
                o_res.range_mm      = r_drd[DD_W-1:INTEN_W];
                o_res.bin_intensity = r_drd[INTEN_W-1:0];
            end
        end else begin
            o_res.revolution_done = r_s3.done;
            o_res.bin_index       = OBIN_W'(r_s3.bin);
            o_res.point_kept      = r_s3.kept;
        end
    end

    assign o_push = r_s3_valid;

endmodule

// File: hw/rtl/lpsb_out_fifo.sv
module lpsb_out_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  lpsb_pkg::t_res               i_res,
    input  logic                         i_stall,
    output logic                         o_valid,
    output lpsb_pkg::t_res               o_res,
    output logic [lpsb_pkg::FIFO_CW-1:0] o_count
);
    import lpsb_pkg::*;

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_CW-1:0] r_cnt;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign o_count = r_cnt;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

endmodule

// File: hw/rtl/lidar_polar_scan_binner_top.sv
// lidar point binner with a double-buffered scan store.
// input channel (i_in_valid / o_in_stall): mode 0 delivers a lidar point, mode 1
// asks for one bin of the last completed revolution. every transaction gives
// exactly one result on the output channel (o_out_valid / i_out_stall), in order.
// one transaction is taken every cycle while o_in_stall is low; the bin index is found
// by a two-stage reciprocal multiply, then an issue stage issues the store access and
// a modify stage merges the written flag into its row of the flag memory
// (read-modify-write, with forwarding of the last row).
// results wait in an 8-entry queue; o_in_stall rises once the queue plus the
// transactions still in the pipeline could fill it, so a stalled receiver backs
// up into the input channel and nothing is dropped.
// reset (i_rst_n low, synchronous) clears the pipeline, the queue, the bank
// select, the previous packet angle and the per-row written flags at once, and
// loads the range and wrap registers with their defaults; no clearing pass.
// configuration writes (i_cfg_valid, always ready) must go in while the block is idle; the block does not enforce it.
module lidar_polar_scan_binner_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [lpsb_pkg::ANGLE_W-1:0]     i_angle_cdeg,
    input  logic [lpsb_pkg::DIST_W-1:0]      i_distance_mm,
    input  logic [lpsb_pkg::INTEN_W-1:0]     i_intensity,
    input  logic                             i_packet_end,
    input  logic [lpsb_pkg::RBIN_W-1:0]      i_read_bin,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_revolution_done,
    output logic [lpsb_pkg::OBIN_W-1:0]      o_bin_index,
    output logic                             o_point_kept,
    output logic [lpsb_pkg::DIST_W-1:0]      o_range_mm,
    output logic [lpsb_pkg::INTEN_W-1:0]     o_bin_intensity,
    output logic                             o_bin_valid,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lpsb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpsb_pkg::CFG_W-1:0]       i_cfg_data
);
    import lpsb_pkg::*;

    t_cfg               r_cfg;
    t_item              in_item;
    logic               in_fire;
    logic               map_valid;
    t_item              map_item;
    logic [Q_W-1:0]     map_q;
    logic [1:0]         map_fill;
    logic               core_push;
    t_res               core_res;
    t_res               out_res;
    logic [FIFO_CW-1:0] fifo_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_range_mm <= CFG_W'(50);
            r_cfg.max_range_mm <= CFG_W'(12000);
            r_cfg.wrap_drop    <= CFG_W'(20000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_RANGE: begin
                    r_cfg.min_range_mm <= i_cfg_data;
                end
                CFG_MAX_RANGE: begin
                    r_cfg.max_range_mm <= i_cfg_data;
                end
                CFG_WRAP_DROP: begin
                    r_cfg.wrap_drop <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // room check counts every transaction that still owes a queue entry
    assign o_in_stall = (fifo_count + FIFO_CW'(map_fill) + FIFO_CW'(core_push))
                        >= FIFO_CW'(FIFO_DEPTH);
    assign in_fire    = i_in_valid && !o_in_stall;

    always_comb begin
        in_item.mode        = i_mode;
        in_item.angle_cdeg  = i_angle_cdeg;
        in_item.distance_mm = i_distance_mm;
        in_item.intensity   = i_intensity;
        in_item.packet_end  = i_packet_end;
        in_item.read_bin    = i_read_bin;
    end

    lpsb_bin_map u_bin_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_fire),
        .i_item  (in_item),
        .o_valid (map_valid),
        .o_item  (map_item),
        .o_q     (map_q),
        .o_fill  (map_fill)
    );

    lpsb_scan_core u_scan_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (map_valid),
        .i_item  (map_item),
        .i_q     (map_q),
        .o_push  (core_push),
        .o_res   (core_res)
    );

    lpsb_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_push),
        .i_res   (core_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .o_count (fifo_count)
    );

    assign o_revolution_done = out_res.revolution_done;
    assign o_bin_index       = out_res.bin_index;
    assign o_point_kept      = out_res.point_kept;
    assign o_range_mm        = out_res.range_mm;
    assign o_bin_intensity   = out_res.bin_intensity;
    assign o_bin_valid       = out_res.bin_valid;

endmodule
